@@ hdl/rsrt_pkg.sv @@
// Shared types and constants for the received sequence range tracker.
package rsrt_pkg;

  localparam int SEQ_W = 32;
  localparam int RH_W  = 5;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0] start;
    logic [SEQ_W-1:0] stop;
  } range_t;

  function automatic logic ser_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

endpackage

@@ hdl/rsrt_if.sv @@
// Request and response channel interfaces of the range tracker.
interface rsrt_req_if;
  import rsrt_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [SEQ_W-1:0] seq_num;
  modport source (output valid, req_type, seq_num, input ready);
  modport sink   (input valid, req_type, seq_num, output ready);
endinterface

interface rsrt_rsp_if;
  import rsrt_pkg::*;
  logic             valid;
  logic             ready;
  logic             was_new;
  logic             seen_before;
  logic             table_full_drop;
  logic [SEQ_W-1:0] cumulative_ack;
  logic [RH_W-1:0]  ranges_held;
  modport source (output valid, was_new, seen_before, table_full_drop, cumulative_ack,
                  ranges_held, input ready);
  modport sink   (input valid, was_new, seen_before, table_full_drop, cumulative_ack,
                  ranges_held, output ready);
endinterface

@@ hdl/rsrt_ram.sv @@
// Generic simple dual-port RAM with registered read.
module rsrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/received_sequence_range_tracker.sv @@
// Received sequence range tracker: top level with range table sequencer.
//
// Requests arrive on req (valid/ready): req_type selects add or query of seq_num.
// Each request yields one item on rsp: was_new, seen_before, table_full_drop,
// the cumulative ack and the number of ranges held after the request.
// Ranges above the ack live in one RAM (registered read, one read and one
// write port), sorted in serial order; a sequencer reads, modifies and
// writes entries back, one entry per cycle.
// Requests at or below the ack and queries on sequence zero go straight to
// the finish state; a query walks the table; an add reads the first and last
// entries for the end checks, then does a table walk or an insert or merge
// shift and, when the head range reaches the ack, a pop shift. One request
// is in flight at a time.
// The result sits in an output register; a new request is taken while it is
// being consumed. A stalled rsp holds req off once the result is pending.
// Reset clears the ack, the zero flag and the range count; the RAM needs no
// clearing since only entries below the count are ever used.
module received_sequence_range_tracker #(
  parameter int MAX_RANGES = 16
) (
  input logic      clk,
  input logic      rst,
  rsrt_req_if.sink   req,
  rsrt_rsp_if.source rsp
);
  import rsrt_pkg::*;

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = AW + 1;
  localparam int RW = 2 * SEQ_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A0    = 4'd1;
  localparam logic [3:0] S_A1    = 4'd2;
  localparam logic [3:0] S_A2    = 4'd3;
  localparam logic [3:0] S_SC0   = 4'd4;
  localparam logic [3:0] S_SC1   = 4'd5;
  localparam logic [3:0] S_SCN   = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_INSW  = 4'd8;
  localparam logic [3:0] S_POP0  = 4'd9;
  localparam logic [3:0] S_POP1  = 4'd10;
  localparam logic [3:0] S_QS0   = 4'd11;
  localparam logic [3:0] S_QSN   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);
  localparam logic [CW-1:0] ONEC = CW'(1);

  logic [3:0]       st, st_next;
  logic [SEQ_W-1:0] s, s_next;
  logic [SEQ_W-1:0] ack, ack_next;
  logic             zseen, zseen_next;
  logic [CW-1:0]    total, total_next;
  logic [AW-1:0]    i, i_next;
  range_t           p, p_next, e0, e0_next;
  logic [AW-1:0]    sh_cur, sh_cur_next;
  logic [CW-1:0]    sh_left, sh_left_next;
  logic             sh_up, sh_up_next, sh_ins, sh_ins_next, sh_pop, sh_pop_next;
  logic             rv, rv_next;
  logic [AW-1:0]    ra, ra_next;
  logic [CW-1:0]    pos, pos_next;
  logic             added, added_next, full, full_next, seen, seen_next;
  logic             ov, ov_next;
  logic             o_new, o_seen, o_full;
  logic [SEQ_W-1:0] o_ack;
  logic [RH_W-1:0]  o_rh;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  range_t           wdata, cs;
  logic [RW-1:0]    rdata_raw;

  logic             ins_req, drop_req, drop_pop;
  logic [CW-1:0]    req_pos;
  logic [CW-1:0]    i_c, ip1, ip2, tm1;
  logic [8:0]       total9;

  rsrt_ram #(.WIDTH(RW), .DEPTH(MAX_RANGES), .AW(AW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign cs        = rdata_raw;
  assign req.ready = (st == S_IDLE) && (!ov || rsp.ready);
  assign i_c       = {1'b0, i};
  assign ip1       = i_c + ONEC;
  assign ip2       = i_c + CW'(2);
  assign tm1       = total - ONEC;
  assign total9    = 9'(total);

  assign rsp.valid           = ov;
  assign rsp.was_new         = o_new;
  assign rsp.seen_before     = o_seen;
  assign rsp.table_full_drop = o_full;
  assign rsp.cumulative_ack  = o_ack;
  assign rsp.ranges_held     = o_rh;

  always_comb begin
    st_next = st; s_next = s; ack_next = ack; zseen_next = zseen; total_next = total;
    i_next = i; p_next = p; e0_next = e0;
    sh_cur_next = sh_cur; sh_left_next = sh_left; sh_up_next = sh_up;
    sh_ins_next = sh_ins; sh_pop_next = sh_pop; rv_next = rv; ra_next = ra;
    pos_next = pos; added_next = added; full_next = full; seen_next = seen;
    ov_next = ov;
    we = 1'b0; waddr = '0; wdata = p; raddr = '0;
    ins_req = 1'b0; drop_req = 1'b0; drop_pop = 1'b0; req_pos = '0;

    if (rsp.valid && rsp.ready) begin
      ov_next = 1'b0;
    end

    unique case (st)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          s_next = req.seq_num;
          added_next = 1'b0; full_next = 1'b0; seen_next = 1'b0;
          if (req.req_type == REQ_ADD) begin
            if (req.seq_num == '0) zseen_next = 1'b1;
            if (ser_lt(ack, req.seq_num)) begin
              if (total == '0) begin
                pos_next = '0;
                st_next = S_INSW;
              end else begin
                st_next = S_A0;
              end
            end else begin
              st_next = S_FIN;
            end
          end else begin
            if (req.seq_num == '0) begin
              seen_next = zseen; st_next = S_FIN;
            end else if (!ser_lt(ack, req.seq_num)) begin
              seen_next = 1'b1; st_next = S_FIN;
            end else if (total == '0) begin
              st_next = S_FIN;
            end else begin
              st_next = S_QS0;
            end
          end
        end
      end
      S_A0: begin
        raddr = '0;
        st_next = S_A1;
      end
      S_A1: begin
        raddr = tm1[AW-1:0];
        e0_next = cs;
        st_next = S_A2;
      end
      S_A2: begin
        if (s + 1'b1 == e0.start) begin
          we = 1'b1; waddr = '0; wdata = '{start: s, stop: e0.stop};
          added_next = 1'b1; st_next = S_POP0;
        end else if (s == cs.stop + 1'b1) begin
          we = 1'b1; waddr = tm1[AW-1:0]; wdata = '{start: cs.start, stop: s};
          added_next = 1'b1; st_next = S_POP0;
        end else if (ser_lt(s, e0.start)) begin
          ins_req = 1'b1; req_pos = '0;
        end else if (ser_lt(cs.stop, s)) begin
          ins_req = 1'b1; req_pos = total;
        end else if (total >= CW'(2)) begin
          st_next = S_SC0;
        end else begin
          st_next = S_POP0;
        end
      end
      S_SC0: begin
        raddr = '0;
        st_next = S_SC1;
      end
      S_SC1: begin
        raddr = AW'(1);
        p_next = cs;
        i_next = '0;
        st_next = S_SCN;
      end
      S_SCN: begin
        raddr = ip2[AW-1:0];
        if (s == p.stop + 1'b1) begin
          added_next = 1'b1;
          we = 1'b1; waddr = i;
          if (s + 1'b1 == cs.start) begin
            wdata = '{start: p.start, stop: cs.stop};
            drop_req = 1'b1; req_pos = ip1;
          end else begin
            wdata = '{start: p.start, stop: s};
            st_next = S_POP0;
          end
        end else if (s + 1'b1 == cs.start) begin
          we = 1'b1; waddr = ip1[AW-1:0]; wdata = '{start: s, stop: cs.stop};
          added_next = 1'b1; st_next = S_POP0;
        end else if (ser_lt(p.stop, s) && ser_lt(s, cs.start)) begin
          ins_req = 1'b1; req_pos = ip1;
        end else if (ip2 < total) begin
          p_next = cs;
          i_next = ip1[AW-1:0];
        end else begin
          st_next = S_POP0;
        end
      end
      S_SHIFT: begin
        if (rv) begin
          we = 1'b1;
          waddr = sh_up ? ra + 1'b1 : ra - 1'b1;
          wdata = cs;
        end
        if (sh_left != '0) begin
          raddr = sh_cur;
          rv_next = 1'b1;
          ra_next = sh_cur;
          sh_cur_next = sh_up ? sh_cur - 1'b1 : sh_cur + 1'b1;
          sh_left_next = sh_left - ONEC;
        end else begin
          rv_next = 1'b0;
          if (sh_ins) st_next = S_INSW;
          else if (sh_pop) st_next = S_FIN;
          else st_next = S_POP0;
        end
      end
      S_INSW: begin
        we = 1'b1; waddr = pos[AW-1:0]; wdata = '{start: s, stop: s};
        total_next = total + ONEC;
        added_next = 1'b1;
        st_next = S_POP0;
      end
      S_POP0: begin
        raddr = '0;
        st_next = (total != '0) ? S_POP1 : S_FIN;
      end
      S_POP1: begin
        if (ack + 1'b1 == cs.start) begin
          ack_next = cs.stop;
          drop_req = 1'b1; drop_pop = 1'b1; req_pos = '0;
        end else begin
          st_next = S_FIN;
        end
      end
      S_QS0: begin
        raddr = '0;
        i_next = '0;
        st_next = S_QSN;
      end
      S_QSN: begin
        raddr = ip1[AW-1:0];
        if (!ser_lt(s, cs.start) && !ser_lt(cs.stop, s)) begin
          seen_next = 1'b1; st_next = S_FIN;
        end else if (ip1 < total) begin
          i_next = ip1[AW-1:0];
        end else begin
          st_next = S_FIN;
        end
      end
      S_FIN: begin
        ov_next = 1'b1;
        st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase

    if (ins_req) begin
      if (total >= MAXC) begin
        full_next = 1'b1;
        st_next = S_POP0;
      end else begin
        pos_next = req_pos;
        sh_cur_next = tm1[AW-1:0];
        sh_left_next = total - req_pos;
        sh_up_next = 1'b1; sh_ins_next = 1'b1; sh_pop_next = 1'b0;
        rv_next = 1'b0;
        st_next = S_SHIFT;
      end
    end
    if (drop_req) begin
      sh_cur_next = AW'(req_pos + ONEC);
      sh_left_next = tm1 - req_pos;
      sh_up_next = 1'b0; sh_ins_next = 1'b0; sh_pop_next = drop_pop;
      rv_next = 1'b0;
      total_next = tm1;
      st_next = S_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; ack <= '0; zseen <= 1'b0; total <= '0; ov <= 1'b0; rv <= 1'b0;
    end else begin
      st <= st_next; ack <= ack_next; zseen <= zseen_next; total <= total_next;
      ov <= ov_next; rv <= rv_next;
    end
    s <= s_next; i <= i_next; p <= p_next; e0 <= e0_next;
    sh_cur <= sh_cur_next; sh_left <= sh_left_next; sh_up <= sh_up_next;
    sh_ins <= sh_ins_next; sh_pop <= sh_pop_next; ra <= ra_next; pos <= pos_next;
    added <= added_next; full <= full_next; seen <= seen_next;
    if (st == S_FIN) begin
      o_new <= added; o_seen <= seen; o_full <= full;
      o_ack <= ack; o_rh <= total9[RH_W-1:0];
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst) total <= MAXC)
    else $error("range count above table size");
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(st) == S_FIN)
    else $error("response raised outside finish");
  a_query_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type == REQ_QUERY) |=> $stable(total) && $stable(ack))
    else $error("query changed table state");
  a_full_no_new: assert property (@(posedge clk) disable iff (rst)
    (st == S_FIN) |-> !(added && full))
    else $error("item both added and dropped");

endmodule
